/* rtl/core/rkd_pkg.sv */
`default_nettype none
package rkd_pkg;

  // stack geometry
  localparam int MaxDigits = 64;
  localparam int AddrW     = $clog2(MaxDigits);
  localparam int FillW     = $clog2(MaxDigits + 1);
  localparam int DigitW    = 4;
  localparam int CountW    = 7;
  localparam int TdataW    = 8;

  localparam logic [FillW-1:0] FillMax = FillW'(MaxDigits);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_TRIM,
    ST_SCAN,
    ST_EMIT,
    ST_ZERO
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic pop;
    logic push;
    logic trim;
    logic scan_start;
    logic scan_next;
    logic emit;
    logic emit_zero;
    logic restart;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_ok;
    logic trim_ok;
    logic fill_zero;
    logic cur_zero;
    logic at_end;
    logic out_free;
    logic item_last;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/rkd_dpath.sv */
`default_nettype none
module rkd_dpath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rkd_pkg::cmd_t              cmd_i,
  output rkd_pkg::sts_t                   sts_o,
  input  wire logic [rkd_pkg::DigitW-1:0] in_digit_i,
  input  wire logic                       in_last_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [rkd_pkg::CountW-1:0] cfg_wdata_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [rkd_pkg::DigitW-1:0]      out_digit_o,
  output logic                            out_last_o,
  output logic                            out_ovf_o
);

  logic [rkd_pkg::DigitW-1:0] mem_q [rkd_pkg::MaxDigits];

  logic [rkd_pkg::DigitW-1:0] digit_q;
  logic                       last_q;
  logic [rkd_pkg::DigitW-1:0] rd_q;
  logic [rkd_pkg::FillW-1:0]  fill_q, fill_d;
  logic [rkd_pkg::CountW-1:0] budget_q, budget_d;
  logic [rkd_pkg::CountW-1:0] count_q;
  logic                       ovf_q, ovf_d;
  logic [rkd_pkg::AddrW-1:0]  ptr_q, ptr_d;
  logic                       out_valid_q;
  logic [rkd_pkg::DigitW-1:0] out_digit_q;
  logic                       out_last_q;
  logic                       out_ovf_q;

  logic [rkd_pkg::AddrW-1:0]  raddr;
  logic [rkd_pkg::FillW-1:0]  fill_dec2;
  logic [rkd_pkg::AddrW-1:0]  ptr_inc;
  logic                       has_room;
  logic                       do_read;
  logic                       at_end;

  assign fill_dec2 = fill_q - rkd_pkg::FillW'(2);
  assign ptr_inc   = ptr_q + rkd_pkg::AddrW'(1);
  assign has_room  = (fill_q < rkd_pkg::FillMax);
  assign at_end    = ({1'b0, ptr_q} + rkd_pkg::FillW'(1)) == fill_q;
  assign do_read   = cmd_i.pop | cmd_i.scan_start | cmd_i.scan_next;

  // single read port: new top after a pop, or the scan position
  always_comb begin
    if (cmd_i.pop) begin
      raddr = fill_dec2[rkd_pkg::AddrW-1:0];
    end else if (cmd_i.scan_start) begin
      raddr = '0;
    end else begin
      raddr = ptr_inc;
    end
  end

  // stack memory with registered read; rd_q doubles as top of stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && has_room) begin
      mem_q[fill_q[rkd_pkg::AddrW-1:0]] <= digit_q;
      rd_q <= digit_q;
    end else if (do_read) begin
      rd_q <= mem_q[raddr];
    end
  end

  // latched input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      digit_q <= in_digit_i;
      last_q  <= in_last_i;
    end
  end

  // fill, budget, overflow and scan pointer
  always_comb begin
    fill_d   = fill_q;
    budget_d = budget_q;
    ovf_d    = ovf_q;
    ptr_d    = ptr_q;
    if (cmd_i.pop || cmd_i.trim) begin
      fill_d   = fill_q - rkd_pkg::FillW'(1);
      budget_d = budget_q - rkd_pkg::CountW'(1);
    end
    if (cmd_i.push) begin
      if (has_room) begin
        fill_d = fill_q + rkd_pkg::FillW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.scan_start) begin
      ptr_d = '0;
    end else if (cmd_i.scan_next) begin
      ptr_d = ptr_inc;
    end
    if (cmd_i.restart) begin
      fill_d   = '0;
      ovf_d    = 1'b0;
      budget_d = count_q;
    end
    if (cfg_we_i) begin
      budget_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      budget_q <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      ptr_q    <= '0;
    end else begin
      fill_q   <= fill_d;
      budget_q <= budget_d;
      ovf_q    <= ovf_d;
      ptr_q    <= ptr_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_zero) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_digit_q <= rd_q;
      out_last_q  <= at_end;
      out_ovf_q   <= ovf_q;
    end else if (cmd_i.emit_zero) begin
      out_digit_q <= '0;
      out_last_q  <= 1'b1;
      out_ovf_q   <= ovf_q;
    end
  end

  // status
  always_comb begin
    sts_o.pop_ok    = (fill_q != '0) && (budget_q != '0) && (rd_q > digit_q);
    sts_o.trim_ok   = (fill_q != '0) && (budget_q != '0);
    sts_o.fill_zero = (fill_q == '0);
    sts_o.cur_zero  = (rd_q == '0);
    sts_o.at_end    = at_end;
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.item_last = last_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_digit_o = out_digit_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule
`default_nettype wire

/* rtl/core/rkd_ctrl.sv */
`default_nettype none
module rkd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rkd_pkg::sts_t sts_i,
  output rkd_pkg::cmd_t      cmd_o
);

  rkd_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rkd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rkd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = rkd_pkg::ST_CMP;
        end
      end
      // pop larger digits while budget lasts, then push
      rkd_pkg::ST_CMP: begin
        if (sts_i.pop_ok) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.push = 1'b1;
          state_d = sts_i.item_last ? rkd_pkg::ST_TRIM : rkd_pkg::ST_IDLE;
        end
      end
      // spend leftover budget from the top
      rkd_pkg::ST_TRIM: begin
        if (sts_i.trim_ok) begin
          cmd_o.trim = 1'b1;
        end else if (sts_i.fill_zero) begin
          state_d = rkd_pkg::ST_ZERO;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = rkd_pkg::ST_SCAN;
        end
      end
      // skip leading zeros
      rkd_pkg::ST_SCAN: begin
        if (sts_i.cur_zero && !sts_i.at_end) begin
          cmd_o.scan_next = 1'b1;
        end else if (sts_i.cur_zero) begin
          state_d = rkd_pkg::ST_ZERO;
        end else begin
          state_d = rkd_pkg::ST_EMIT;
        end
      end
      rkd_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.at_end) begin
            cmd_o.restart = 1'b1;
            state_d = rkd_pkg::ST_IDLE;
          end else begin
            cmd_o.scan_next = 1'b1;
          end
        end
      end
      rkd_pkg::ST_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.emit_zero = 1'b1;
          cmd_o.restart   = 1'b1;
          state_d = rkd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rkd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/remove_k_digits_min_number.sv */
`default_nettype none
// Smallest number left after removing removal_count digits. Digits enter one
// word at a time, most significant first, tlast on the final digit. Each
// digit is compared against the stack top, and each digit popped off the
// stack repeats that compare, since it loops through the stack memory's
// single registered read port. After the final digit, leftover budget trims
// one digit per cycle, leading zeros are skipped at one per cycle, and the
// result goes out one digit per cycle unless stalled, with tlast on its last
// digit (a single 0 if nothing remains). tuser flags that a digit was dropped
// because the 64-entry stack was full. A new number may start while the last
// result word still waits in the output register. Write removal_count only
// while the block is idle; the write also reloads the budget at once.
module remove_k_digits_min_number (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rkd_pkg::CountW-1:0] cfg_wdata_i,   // removal_count
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [rkd_pkg::TdataW-1:0] s_axis_tdata,  // [3:0] digit_value
  input  wire logic                       s_axis_tlast,  // is_final_digit
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [rkd_pkg::TdataW-1:0]      m_axis_tdata,  // [3:0] result_digit
  output logic                            m_axis_tlast,  // is_last_result
  output logic                            m_axis_tuser   // [0] overflow_seen
);

  rkd_pkg::cmd_t              cmd;
  rkd_pkg::sts_t              sts;
  logic [rkd_pkg::DigitW-1:0] out_digit;

  rkd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rkd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_digit_i  (s_axis_tdata[rkd_pkg::DigitW-1:0]),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_digit_o (out_digit),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

  // zero-pad the result digit to a whole byte
  assign m_axis_tdata = {{(rkd_pkg::TdataW - rkd_pkg::DigitW){1'b0}}, out_digit};

endmodule
`default_nettype wire
